// ===== hdl/frame_sequence_gap_counter_defines.svh =====
// ---------------------------------------------------------------------------
// frame sequence gap counter assertion macros
// shared check forms used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef FRAME_SEQUENCE_GAP_COUNTER_DEFINES_SVH
`define FRAME_SEQUENCE_GAP_COUNTER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define FSGC_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fsgc: check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define FSGC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fsgc: check failed");

`endif

// ===== hdl/fsgc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsgc_pkg
// widths, codes and word types of the frame sequence gap counter
// ---------------------------------------------------------------------------
package fsgc_pkg;

  localparam int THREAD_W  = 10;
  localparam int LEN_W     = 27;
  localparam int DAY_W     = 17;
  localparam int SEC_W     = 17;
  localparam int FRAME_W   = 24;
  localparam int MISS_W    = 13;
  localparam int COUNT_W   = 48;
  localparam int STATUS_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 27;

  localparam int MAX_GAP = 4096;
  localparam logic [MISS_W-1:0] GAP_LIMIT = MISS_W'(MAX_GAP);

  localparam logic [SEC_W:0] SECONDS_PER_DAY = (SEC_W+1)'(86400);

  localparam logic [THREAD_W-1:0] TARGET_THREAD_RST = '0;
  localparam logic [FRAME_W-1:0]  FRAMES_PER_SEC_RST = FRAME_W'(1);
  localparam logic [LEN_W-1:0]    FRAME_BYTES_RST = LEN_W'(8032);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_THREAD     = 2'd0,
    CFG_FRAMES_PER_SECOND = 2'd1,
    CFG_FRAME_BYTES       = 2'd2
  } cfg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 2'd0,
    ST_LENGTH_CHANGED = 2'd1,
    ST_GAP_RESYNC     = 2'd2,
    ST_HALTED         = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_TARGET = 2'd1,
    CLS_LENGTH = 2'd2,
    CLS_HALTED = 2'd3
  } frame_class_t;

  typedef struct packed {
    logic [THREAD_W-1:0] thread_id;
    logic [LEN_W-1:0]    frame_length;
    logic [DAY_W-1:0]    day_number;
    logic [SEC_W-1:0]    second_of_day;
    logic [FRAME_W-1:0]  frame_in_second;
  } in_word_t;

  typedef struct packed {
    logic                matched;
    logic [MISS_W-1:0]   missed_here;
    logic [COUNT_W-1:0]  frames_seen;
    logic [COUNT_W-1:0]  frames_lost;
    logic                second_done;
    logic [SEC_W-1:0]    second_reported;
    logic [STATUS_W-1:0] status;
  } out_word_t;

  typedef struct packed {
    logic [THREAD_W-1:0] target_thread;
    logic [FRAME_W-1:0]  frames_per_second;
    logic [LEN_W-1:0]    expected_frame_bytes;
  } cfg_t;

  // classified frame handed from front to back
  typedef struct packed {
    frame_class_t       cls;
    logic [DAY_W-1:0]   day;
    logic [SEC_W-1:0]   second;
    logic [FRAME_W-1:0] frame;
  } job_t;

  typedef struct packed {
    logic [QUEUE_CNT_W-1:0] count;
    logic                   empty;
    logic                   full;
  } queue_stat_t;

endpackage

// ===== hdl/fsgc_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsgc channel interfaces
// valid/ready channels for frame header words and result words
// ---------------------------------------------------------------------------
interface fsgc_in_if import fsgc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fsgc_out_if import fsgc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/frame_sequence_gap_counter.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frame_sequence_gap_counter
// One decoded frame header word in, one result word out. Frames of other
// threads, frames with a bad length and frames after a halt are answered
// from the idle state of the back end. For a frame of the target thread the
// back end walks the expected counter over n missing frames until its
// timestamp is reached (0 to 4096; 4096 also when the gap is too large and
// the counter resyncs), stepping it one frame per cycle. The front end
// takes a header word every cycle while the four-entry queue has room, and
// the result register lets the walk for the next target frame run while a
// result waits.
// ---------------------------------------------------------------------------
`include "frame_sequence_gap_counter_defines.svh"

module frame_sequence_gap_counter import fsgc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  fsgc_in_if.sink               frame_in,
  fsgc_out_if.source            result_out
);

  cfg_t        cfg;
  job_t        push_job;
  job_t        head;
  logic        push;
  logic        pop;
  logic        halted;
  queue_stat_t q_stat;
  logic        done_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_thread        <= TARGET_THREAD_RST;
      cfg.frames_per_second    <= FRAMES_PER_SEC_RST;
      cfg.expected_frame_bytes <= FRAME_BYTES_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TARGET_THREAD:     cfg.target_thread <= cfg_data[THREAD_W-1:0];
        CFG_FRAMES_PER_SECOND: cfg.frames_per_second <= cfg_data[FRAME_W-1:0];
        CFG_FRAME_BYTES:       cfg.expected_frame_bytes <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  fsgc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .cfg      (cfg),
    .q_full   (q_stat.full),
    .push     (push),
    .job      (push_job),
    .halted   (halted)
  );

  fsgc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  fsgc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .frames_per_second (cfg.frames_per_second),
    .head              (head),
    .q_empty           (q_stat.empty),
    .pop               (pop),
    .result_out        (result_out)
  );

  assign done_word = result_out.valid && result_out.data.second_done;

  // a full queue must hold off the input side
  `FSGC_ASSERT_IMPLY(a_full_blocks_input, q_stat.full, !frame_in.ready)

  // a finished second only comes with a target frame
  `FSGC_ASSERT_IMPLY(a_second_done_target, done_word, result_out.data.matched)

  // halt is sticky until reset
  `FSGC_ASSERT_NEXT(a_halt_sticky, halted, halted)

endmodule

// ===== hdl/fsgc_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsgc_front
// accepts header words, checks length and thread, owns the halt flag
// ---------------------------------------------------------------------------
module fsgc_front import fsgc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fsgc_in_if.sink    frame_in,
  input  cfg_t       cfg,
  input  logic       q_full,
  output logic       push,
  output job_t       job,
  output logic       halted
);

  logic accept;
  logic len_bad;

  assign frame_in.ready = !q_full;
  assign accept = frame_in.valid && frame_in.ready;
  assign push = accept;
  assign len_bad = frame_in.data.frame_length != cfg.expected_frame_bytes;

  always_comb begin
    job.day    = frame_in.data.day_number;
    job.second = frame_in.data.second_of_day;
    job.frame  = frame_in.data.frame_in_second;
    if (halted) begin
      job.cls = CLS_HALTED;
    end else if (len_bad) begin
      job.cls = CLS_LENGTH;
    end else if (frame_in.data.thread_id == cfg.target_thread) begin
      job.cls = CLS_TARGET;
    end else begin
      job.cls = CLS_OTHER;
    end
  end

  // a length change halts the block until reset; later frames are classed as halted
  always_ff @(posedge clk) begin
    if (rst) begin
      halted <= 1'b0;
    end else if (accept && !halted && len_bad) begin
      halted <= 1'b1;
    end
  end

endmodule

// ===== hdl/fsgc_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsgc_queue
// short queue of classified frames between front and back
// ---------------------------------------------------------------------------
module fsgc_queue import fsgc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  job_t        push_job,
  input  logic        pop,
  output job_t        head,
  output queue_stat_t stat
);

  job_t                   slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  assign head = slots[rd_ptr];
  assign stat.count = count;
  assign stat.empty = count == '0;
  assign stat.full  = count == QUEUE_CNT_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/fsgc_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsgc_back
// walks the expected frame counter, keeps totals, drives the result word
// ---------------------------------------------------------------------------
module fsgc_back import fsgc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [FRAME_W-1:0] frames_per_second,
  input  job_t              head,
  input  logic              q_empty,
  output logic              pop,
  fsgc_out_if.source        result_out
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_POST = 3'b100
  } back_state_t;

  back_state_t        state;
  logic               seeded;
  logic [DAY_W-1:0]   next_day;
  logic [SEC_W-1:0]   next_second;
  logic [FRAME_W-1:0] next_frame;
  logic [COUNT_W-1:0] read_total;
  logic [COUNT_W-1:0] lost_total;
  job_t               cur;
  logic [MISS_W-1:0]  walked;
  logic [MISS_W-1:0]  missed;
  logic               resync;
  logic               out_valid;
  out_word_t          out_data;

  logic               slot_free;
  logic [FRAME_W:0]   frame_inc;
  logic               frame_wrap;
  logic [FRAME_W-1:0] frame_step;
  logic [SEC_W:0]     sec_inc;
  logic               sec_wrap;
  logic [SEC_W-1:0]   sec_step;
  logic [DAY_W-1:0]   day_step;
  logic               hit;
  logic [COUNT_W:0]   lost_sum;
  logic [COUNT_W-1:0] lost_sat;
  logic [COUNT_W-1:0] read_sat;
  logic               emit_plain;
  logic               emit_target;
  logic               start_target;
  status_t            plain_status;

  assign slot_free = !out_valid || result_out.ready;
  assign result_out.valid = out_valid;
  assign result_out.data  = out_data;

  // one step of the expected (day, second, frame) counter
  always_comb begin
    frame_inc  = {1'b0, next_frame} + 1'b1;
    frame_wrap = frame_inc >= {1'b0, frames_per_second};
    frame_step = frame_wrap ? '0 : frame_inc[FRAME_W-1:0];
    sec_inc    = {1'b0, next_second} + 1'b1;
    sec_wrap   = sec_inc >= SECONDS_PER_DAY;
    sec_step   = sec_wrap ? '0 : sec_inc[SEC_W-1:0];
    day_step   = next_day + 1'b1;
  end

  assign hit = (next_day == cur.day) && (next_second == cur.second) &&
               (next_frame == cur.frame);

  assign lost_sum = {1'b0, lost_total} + {{(COUNT_W+1-MISS_W){1'b0}}, walked};
  assign lost_sat = lost_sum[COUNT_W] ? '1 : lost_sum[COUNT_W-1:0];
  assign read_sat = (read_total == '1) ? read_total : read_total + 1'b1;

  always_comb begin
    case (head.cls)
      CLS_LENGTH: plain_status = ST_LENGTH_CHANGED;
      CLS_HALTED: plain_status = ST_HALTED;
      default:    plain_status = ST_OK;
    endcase
  end

  assign start_target = (state == S_IDLE) && !q_empty && (head.cls == CLS_TARGET);
  assign emit_plain   = (state == S_IDLE) && !q_empty && (head.cls != CLS_TARGET) &&
                        slot_free;
  assign emit_target  = (state == S_POST) && slot_free;
  assign pop          = start_target || emit_plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seeded      <= 1'b0;
      next_day    <= '0;
      next_second <= '0;
      next_frame  <= '0;
      read_total  <= '0;
      lost_total  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit_plain || emit_target) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start_target) begin
            cur        <= head;
            walked     <= '0;
            read_total <= read_sat;
            if (!seeded) begin
              seeded      <= 1'b1;
              next_day    <= head.day;
              next_second <= head.second;
              next_frame  <= head.frame;
            end
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (hit) begin
            missed     <= walked;
            resync     <= 1'b0;
            lost_total <= lost_sat;
            state      <= S_POST;
          end else if (walked == GAP_LIMIT) begin
            // gap too large: take the frame's own timestamp
            missed      <= '0;
            resync      <= 1'b1;
            next_day    <= cur.day;
            next_second <= cur.second;
            next_frame  <= cur.frame;
            state       <= S_POST;
          end else begin
            next_frame <= frame_step;
            if (frame_wrap) begin
              next_second <= sec_step;
              if (sec_wrap) begin
                next_day <= day_step;
              end
            end
            walked <= walked + 1'b1;
          end
        end
        S_POST: begin
          if (emit_target) begin
            next_frame <= frame_step;
            if (frame_wrap) begin
              next_second <= sec_step;
              if (sec_wrap) begin
                next_day <= day_step;
              end
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    if (emit_plain) begin
      out_data.matched         <= 1'b0;
      out_data.missed_here     <= '0;
      out_data.frames_seen     <= read_total;
      out_data.frames_lost     <= lost_total;
      out_data.second_done     <= 1'b0;
      out_data.second_reported <= '0;
      out_data.status          <= plain_status;
    end else if (emit_target) begin
      out_data.matched         <= 1'b1;
      out_data.missed_here     <= missed;
      out_data.frames_seen     <= read_total;
      out_data.frames_lost     <= lost_total;
      out_data.second_done     <= frame_wrap;
      out_data.second_reported <= frame_wrap ? sec_inc[SEC_W-1:0] : '0;
      out_data.status          <= resync ? ST_GAP_RESYNC : ST_OK;
    end
  end

endmodule
